// ===== hdl/pfsc_pkg.sv =====
// -----------------------------------------------------------------------------
// pfsc_pkg - shared types and constants for the PCM/float sample converter
// Format codes, operation codes, the queued word layout and a leading-one search.
// -----------------------------------------------------------------------------
package pfsc_pkg;

   // device sample formats held in the format register
   typedef enum logic [2:0] {
      FMT_INT16 = 3'd0,
      FMT_INT24 = 3'd1,
      FMT_INT32 = 3'd2,
      FMT_F32   = 3'd3,
      FMT_F64   = 3'd4,
      FMT_UNSUP = 3'd5
   } fmt_type;

   typedef enum logic {
      OP_DECODE = 1'b0,
      OP_ENCODE = 1'b1
   } op_type;

   localparam logic [2:0]  FMT_RESET   = FMT_F32;
   localparam logic [31:0] F32_POS_ONE = 32'h3F80_0000;
   localparam logic [31:0] F32_NEG_ONE = 32'hBF80_0000;
   localparam logic [31:0] K_INT16     = 32'd32767;
   localparam logic [31:0] K_INT24     = 32'd8388607;
   // 2147483647.0f rounds to 2^31 in single precision
   localparam logic [31:0] K_INT32     = 32'h8000_0000;
   localparam logic [31:0] INT32_MAX   = 32'h7FFF_FFFF;

   // classified word passed from front to back
   typedef struct packed {
      logic        op;
      logic [2:0]  fmt;
      logic        unsup;
      logic        last;
      logic [63:0] dev;
      logic [31:0] cval;
   } item_type;

   // position of the highest set bit, zero for an all-zero word
   function automatic logic [4:0] lead_pos32(input logic [31:0] v);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) p = 5'(i);
      end
      return p;
   endfunction

endpackage

// ===== hdl/pfsc_req_if.sv =====
// -----------------------------------------------------------------------------
// pfsc_req_if - request channel
// Valid/ready channel carrying one sample word to convert.
// -----------------------------------------------------------------------------
interface pfsc_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [63:0] device_word;
   logic [31:0] float_word;
   logic        block_last;

   modport source (output valid, operation, device_word, float_word, block_last,
                   input ready);
   modport sink   (input valid, operation, device_word, float_word, block_last,
                   output ready);
endinterface

// ===== hdl/pfsc_rsp_if.sv =====
// -----------------------------------------------------------------------------
// pfsc_rsp_if - response channel
// Valid/ready channel carrying one converted sample word.
// -----------------------------------------------------------------------------
interface pfsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_word;
   logic        format_unsupported;
   logic        block_last_out;

   modport source (output valid, result_word, format_unsupported, block_last_out,
                   input ready);
   modport sink   (input valid, result_word, format_unsupported, block_last_out,
                   output ready);
endinterface

// ===== hdl/pfsc_front.sv =====
// -----------------------------------------------------------------------------
// pfsc_front - format register and input classification
// Holds the device format, flags unsupported codes and clamps encode inputs.
// -----------------------------------------------------------------------------
module pfsc_front import pfsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_write_data,
   input  logic        operation,
   input  logic [63:0] device_word,
   input  logic [31:0] float_word,
   input  logic        block_last,
   output item_type    item
);

   logic [2:0] fmt_ff;
   logic       is_nan;

   // format register
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_RESET;
      end else if (csr_write_enable) begin
         fmt_ff <= csr_write_data;
      end
   end

   assign is_nan = (float_word[30:23] == 8'hFF) && (float_word[22:0] != '0);

   // classify and clamp to [-1,1], NaN goes to +1
   always_comb begin
      item.op    = operation;
      item.fmt   = fmt_ff;
      item.unsup = (fmt_ff > FMT_F64);
      item.last  = block_last;
      item.dev   = device_word;
      priority if (is_nan) begin
         item.cval = F32_POS_ONE;
      end else if (float_word[30:0] > F32_POS_ONE[30:0]) begin
         item.cval = float_word[31] ? F32_NEG_ONE : F32_POS_ONE;
      end else begin
         item.cval = float_word;
      end
   end

endmodule

// ===== hdl/pfsc_queue.sv =====
// -----------------------------------------------------------------------------
// pfsc_queue - short word queue between front and back
// Small register FIFO; full and empty decoupled through a fill count.
// -----------------------------------------------------------------------------
module pfsc_queue import pfsc_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output item_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, rd_ff;
   logic [CW-1:0]   cnt_ff;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ff];

   // store pushed words
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   // advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule

// ===== hdl/pfsc_back.sv =====
// -----------------------------------------------------------------------------
// pfsc_back - conversion datapath
// Stage one: sign/magnitude, leading-one search and scale multiply.
// Stage two: rounding, packing and the output register.
// -----------------------------------------------------------------------------
module pfsc_back import pfsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  item_type    in_item,
   output logic        in_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] result_word,
   output logic        format_unsupported,
   output logic        block_last_out
);

   logic        advance;

   // stage one registers
   logic        s1_v_ff;
   item_type    s1_item_ff;
   logic        s1_isign_ff;
   logic [31:0] s1_mag_ff;
   logic [4:0]  s1_mlp_ff;
   logic [55:0] s1_prod_ff;
   logic [4:0]  s1_slp_ff;

   // stage one next values
   logic [31:0] sext_in, mag_in, k_in;
   logic [23:0] m24_in;
   logic        isign_in;

   // output registers
   logic        out_v_ff;
   logic [63:0] out_word_ff;
   logic        out_unsup_ff, out_last_ff;
   logic [63:0] word_in;

   assign advance = !out_v_ff || rsp_ready;
   assign in_pop  = advance && in_valid;

   // sign-extend the device integer and pick the scale constant
   always_comb begin
      unique case (in_item.fmt)
         FMT_INT16: begin
            sext_in = {{16{in_item.dev[15]}}, in_item.dev[15:0]};
            k_in    = K_INT16;
         end
         FMT_INT24: begin
            sext_in = {{8{in_item.dev[23]}}, in_item.dev[23:0]};
            k_in    = K_INT24;
         end
         default: begin
            sext_in = in_item.dev[31:0];
            k_in    = K_INT32;
         end
      endcase
      isign_in = sext_in[31];
      mag_in   = isign_in ? (~sext_in + 32'd1) : sext_in;
      m24_in   = (in_item.cval[30:23] != '0) ? {1'b1, in_item.cval[22:0]} : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff  <= in_item;
         s1_isign_ff <= isign_in;
         s1_mag_ff   <= mag_in;
         s1_mlp_ff   <= lead_pos32(mag_in);
         s1_prod_ff  <= m24_in * k_in;
         s1_slp_ff   <= lead_pos32({9'b0, in_item.cval[22:0]});
      end
   end

   // stage two: finish the selected conversion
   always_comb begin
      logic [63:0] dev;
      logic [31:0] cv;
      // integer decode
      logic [7:0]  scl, ie8;
      logic [4:0]  id;
      logic [23:0] isig;
      logic        iup;
      logic [31:0] ires;
      // float64 decode
      logic        fs;
      logic [10:0] fe;
      logic [51:0] fm;
      logic signed [12:0] e8s, tt;
      logic [5:0]  ft;
      logic [63:0] sig64;
      logic [30:0] fq;
      logic        fup;
      logic [31:0] fres;
      // float64 widen
      logic [63:0] wres;
      // integer encode
      logic [5:0]  ed;
      logic [24:0] rm;
      logic        eup;
      logic signed [9:0] ssh;
      logic [9:0]  nsh;
      logic [32:0] im;
      logic [31:0] iv;
      logic [63:0] eres;

      dev = s1_item_ff.dev;
      cv  = s1_item_ff.cval;

      // integer to float, round to nearest even above 24 bits
      unique case (s1_item_ff.fmt)
         FMT_INT16: scl = 8'd15;
         FMT_INT24: scl = 8'd23;
         default:   scl = 8'd31;
      endcase
      ie8  = 8'd127 + {3'b0, s1_mlp_ff} - scl;
      id   = '0;
      iup  = 1'b0;
      if (s1_mlp_ff <= 5'd23) begin
         isig = 24'(s1_mag_ff << (5'd23 - s1_mlp_ff));
      end else begin
         id   = s1_mlp_ff - 5'd23;
         isig = 24'(s1_mag_ff >> id);
         iup  = s1_mag_ff[id - 5'd1] &&
                ((|(s1_mag_ff & ((32'd1 << (id - 5'd1)) - 32'd1))) || isig[0]);
      end
      ires = (s1_mag_ff == '0) ? '0 :
             {s1_isign_ff, 31'({ie8, isig[22:0]}) + 31'(iup)};

      // float64 to float32
      fs    = dev[63];
      fe    = dev[62:52];
      fm    = dev[51:0];
      e8s   = $signed({2'b0, fe}) - 13'sd896;
      sig64 = {11'b0, (fe != '0), fm};
      tt    = 13'sd30 - e8s;
      if (e8s >= 13'sd1)      ft = 6'd29;
      else if (tt > 13'sd63)  ft = 6'd63;
      else                    ft = tt[5:0];
      fq    = (e8s >= 13'sd1) ? {e8s[7:0], 23'(sig64 >> 29)} : {8'b0, 23'(sig64 >> ft)};
      fup   = sig64[ft - 6'd1] &&
              ((|(sig64 & ((64'd1 << (ft - 6'd1)) - 64'd1))) || fq[0]);
      priority if (fe == 11'h7FF && fm != '0) begin
         fres = {fs, 8'hFF, 1'b1, fm[50:29]};
      end else if (fe == 11'h7FF || e8s >= 13'sd255) begin
         fres = {fs, 8'hFF, 23'b0};
      end else begin
         fres = {fs, fq + 31'(fup)};
      end

      // float32 to float64, subnormals normalised
      priority if (cv[30:0] == '0) begin
         wres = {cv[31], 63'b0};
      end else if (cv[30:23] != '0) begin
         wres = {cv[31], 11'(cv[30:23]) + 11'd896, cv[22:0], 29'b0};
      end else begin
         wres = {cv[31], 11'd874 + 11'(s1_slp_ff),
                 52'({cv[22:0], 29'b0} << (5'd23 - s1_slp_ff))};
      end

      // round the scaled product to single, then truncate toward zero
      unique case (s1_item_ff.fmt)
         FMT_INT16: ed = s1_prod_ff[38] ? 6'd15 : 6'd14;
         FMT_INT24: ed = s1_prod_ff[46] ? 6'd23 : 6'd22;
         default:   ed = 6'd31;
      endcase
      rm  = 25'(s1_prod_ff >> ed);
      eup = s1_prod_ff[ed - 6'd1] &&
            ((|(s1_prod_ff & ((56'd1 << (ed - 6'd1)) - 56'd1))) || rm[0]);
      rm  = rm + 25'(eup);
      ssh = $signed({4'b0, ed}) + $signed({2'b0, cv[30:23]}) - 10'sd150;
      nsh = 10'(-ssh);
      if (cv[30:23] == '0)        im = '0;
      else if (ssh >= 10'sd0)     im = {8'b0, rm} << ssh[3:0];
      else if (nsh > 10'd40)      im = '0;
      else                        im = {8'b0, rm} >> nsh[5:0];
      if (!cv[31] && im[32:31] != '0) iv = INT32_MAX;
      else if (cv[31])                iv = 32'(~im + 33'd1);
      else                            iv = im[31:0];
      unique case (s1_item_ff.fmt)
         FMT_INT16: eres = {48'b0, iv[15:0]};
         FMT_INT24: eres = {40'b0, iv[23:0]};
         default:   eres = {32'b0, iv};
      endcase

      // select the result
      if (s1_item_ff.unsup) begin
         word_in = '0;
      end else if (s1_item_ff.op == OP_DECODE) begin
         unique case (s1_item_ff.fmt)
            FMT_INT16, FMT_INT24, FMT_INT32: word_in = {32'b0, ires};
            FMT_F32:                         word_in = {32'b0, dev[31:0]};
            default:                         word_in = {32'b0, fres};
         endcase
      end else begin
         unique case (s1_item_ff.fmt)
            FMT_INT16, FMT_INT24, FMT_INT32: word_in = eres;
            FMT_F32:                         word_in = {32'b0, cv};
            default:                         word_in = wres;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (advance) begin
         out_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff  <= word_in;
         out_unsup_ff <= s1_item_ff.unsup;
         out_last_ff  <= s1_item_ff.last;
      end
   end

   assign rsp_valid          = out_v_ff;
   assign result_word        = out_word_ff;
   assign format_unsupported = out_unsup_ff;
   assign block_last_out     = out_last_ff;

endmodule

// ===== hdl/pcm_float_sample_converter.sv =====
// -----------------------------------------------------------------------------
// pcm_float_sample_converter - PCM integer / IEEE single sample converter
// Converts a word per unstalled cycle between an audio device format and float32.
// -----------------------------------------------------------------------------
// One word is taken per clock when the queue has room. Each accepted word is
// written into the queue, moves into the multiply and leading-one stage, and
// then into the output register, where it is held until taken. Throughput is
// one word per cycle, limited by the output register handshake. The user must
// write the device format through csr_write_enable only while no word is in
// flight; the block does not enforce this. Codes 5 to 7 return zero with
// format_unsupported set.
module pcm_float_sample_converter import pfsc_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   pfsc_req_if.sink    req_chan,
   pfsc_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_write_data
);

   item_type front_item, queue_item;
   logic     q_full, q_not_empty, q_pop, push;

   assign req_chan.ready = !q_full;
   assign push           = req_chan.valid && !q_full;

   pfsc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .operation        (req_chan.operation),
      .device_word      (req_chan.device_word),
      .float_word       (req_chan.float_word),
      .block_last       (req_chan.block_last),
      .item             (front_item)
   );

   pfsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (queue_item)
   );

   pfsc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (q_not_empty),
      .in_item            (queue_item),
      .in_pop             (q_pop),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .result_word        (rsp_chan.result_word),
      .format_unsupported (rsp_chan.format_unsupported),
      .block_last_out     (rsp_chan.block_last_out)
   );

endmodule

// ===== hdl/pfsc_checker.sv =====
// -----------------------------------------------------------------------------
// pfsc_checker - port-level checks for the sample converter
// Tracks words in flight and checks result and handshake behaviour.
// -----------------------------------------------------------------------------
module pfsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] result_word,
   input logic        format_unsupported
);

   logic [7:0] pending_ff;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // count words accepted but not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 8'(req_take) - 8'(rsp_take);
      end
   end

   a_no_invented_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result shown with no word in flight");

   a_unsup_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && format_unsupported |-> result_word == '0)
      else $error("unsupported format gave a non-zero result");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_word))
      else $error("stalled result changed");

endmodule

bind pcm_float_sample_converter pfsc_checker u_pfsc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .result_word        (rsp_chan.result_word),
   .format_unsupported (rsp_chan.format_unsupported)
);

// ===== test/tb_pcm_float_sample_converter.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_pcm_float_sample_converter - self-checking bench for the sample converter
// Runs a directed table, then random words over many device formats. Results are
// checked against typed rows or a bit-exact integer model of float conversions.
// -----------------------------------------------------------------------------
module tb_pcm_float_sample_converter;
   import pfsc_pkg::*;

   // spare format codes beyond the enum, both unsupported
   localparam logic [2:0] FMT_SPARE6 = 3'd6;
   localparam logic [2:0] FMT_SPARE7 = 3'd7;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int HOLD_CYCLES  = 80;
   localparam int PHASE_WORDS  = 72;

   typedef struct packed {
      logic [63:0] word;
      logic        unsup;
      logic        last;
   } sample_out_type;

   typedef struct packed {
      logic [2:0]  fmt;
      logic        op;
      logic [63:0] dev;
      logic [31:0] flt;
      logic        last;
      logic        typed;
      logic [63:0] want_word;
      logic        want_unsup;
   } table_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [2:0] csr_write_data;

   pfsc_req_if req_bus ();
   pfsc_rsp_if rsp_bus ();

   pcm_float_sample_converter dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   sample_out_type pending_samples[$];
   table_row_type  stim_table[$];
   logic [2:0]     active_fmt;
   int             mismatch_count;
   int             idle_pct;
   int             hold_request;
   int             cycle_count;

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // round mag * 2^scale to single precision, nearest even
   function automatic logic [31:0] round_to_single(input logic sgn, input int scale,
                                                   input logic [63:0] mag);
      int top;
      int lsb;
      int sh;
      logic [127:0] ext;
      logic [63:0] q;
      logic [63:0] bits;
      if (mag == 64'd0) return {sgn, 31'd0};
      top = 0;
      for (int i = 0; i < 64; i++) if (mag[i]) top = i;
      lsb = top + scale - 23;
      if (lsb < -149) lsb = -149;
      sh = lsb - scale;
      if (sh <= 0) begin
         q = mag << (-sh);
      end else if (sh > 64) begin
         q = 64'd0;
      end else begin
         ext = {mag, 64'd0} >> sh;
         q = ext[127:64];
         if (ext[63] && (ext[62:0] != 0 || q[0])) q = q + 64'd1;
      end
      // hidden bit carries into the exponent field
      bits = (64'(lsb + 149) << 23) + q;
      if (bits >= 64'h7F80_0000) bits = 64'h7F80_0000;
      return {sgn, bits[30:0]};
   endfunction

   // double to single, NaN keeps sign and top payload bits
   function automatic logic [31:0] narrow_double(input logic [63:0] d);
      logic [10:0] ex;
      logic [51:0] man;
      ex = d[62:52];
      man = d[51:0];
      if (ex == 11'h7FF) begin
         if (man != 0) return {d[63], 8'hFF, 1'b1, man[50:29]};
         return {d[63], 31'h7F80_0000};
      end
      if (ex == 0) return round_to_single(d[63], -1074, {12'd0, man});
      return round_to_single(d[63], int'(ex) - 1075, {11'd1, man});
   endfunction

   // clamp to [-1,1], NaN to +1
   function automatic logic [31:0] clamp_unit(input logic [31:0] f);
      if (f[30:23] == 8'hFF && f[22:0] != 0) return F32_POS_ONE;
      if (f[30:0] > 31'h3F80_0000) return f[31] ? F32_NEG_ONE : F32_POS_ONE;
      return f;
   endfunction

   // single-precision product, truncate toward zero, saturate at 32 bits
   function automatic longint scale_truncate(input logic [31:0] c, input logic [31:0] k);
      logic [63:0] mc;
      int ec;
      logic [31:0] pb;
      int ex;
      longint iv;
      if (c[30:23] == 0) begin
         mc = {41'd0, c[22:0]};
         ec = -149;
      end else begin
         mc = {40'd0, 1'b1, c[22:0]};
         ec = int'(c[30:23]) - 150;
      end
      pb = round_to_single(c[31], ec, mc * {32'd0, k});
      ex = int'(pb[30:23]);
      if (ex >= 158) return pb[31] ? -longint'(64'h8000_0000) : longint'(INT32_MAX);
      if (ex < 127) return 0;
      iv = longint'({1'b1, pb[22:0]});
      iv = (ex >= 150) ? (iv << (ex - 150)) : (iv >> (150 - ex));
      return pb[31] ? -iv : iv;
   endfunction

   // widen single to double exactly
   function automatic logic [63:0] widen_single(input logic [31:0] c);
      int top;
      logic [63:0] m;
      if (c[30:0] == 0) return {c[31], 63'd0};
      if (c[30:23] != 0)
         return {c[31], 11'(int'(c[30:23]) + 896), c[22:0], 29'd0};
      top = 0;
      for (int i = 0; i < 23; i++) if (c[i]) top = i;
      m = {41'd0, c[22:0]} << (52 - top);
      return {c[31], 11'(top - 149 + 1023), m[51:0]};
   endfunction

   // integer PCM value times 2^scale
   function automatic logic [31:0] int_to_single(input longint v, input int scale);
      if (v < 0) return round_to_single(1'b1, scale, 64'(-v));
      return round_to_single(1'b0, scale, 64'(v));
   endfunction

   // expected converted sample for one request word
   function automatic sample_out_type convert_sample(input logic [2:0] fmt, input logic op,
                                                     input logic [63:0] dev,
                                                     input logic [31:0] flt,
                                                     input logic last);
      sample_out_type r;
      logic [31:0] c;
      r.word = 64'd0;
      r.unsup = (fmt > FMT_F64);
      r.last = last;
      if (r.unsup) return r;
      if (op == OP_DECODE) begin
         case (fmt)
            FMT_INT16: r.word = {32'd0, int_to_single(longint'(signed'(dev[15:0])), -15)};
            FMT_INT24: r.word = {32'd0, int_to_single(longint'(signed'(dev[23:0])), -23)};
            FMT_INT32: r.word = {32'd0, int_to_single(longint'(signed'(dev[31:0])), -31)};
            FMT_F32:   r.word = {32'd0, dev[31:0]};
            default:   r.word = {32'd0, narrow_double(dev)};
         endcase
      end else begin
         c = clamp_unit(flt);
         case (fmt)
            FMT_INT16: r.word = {48'd0, 16'(scale_truncate(c, K_INT16))};
            FMT_INT24: r.word = {40'd0, 24'(scale_truncate(c, K_INT24))};
            FMT_INT32: r.word = {32'd0, 32'(scale_truncate(c, K_INT32))};
            FMT_F32:   r.word = {32'd0, c};
            default:   r.word = widen_single(c);
         endcase
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      sample_out_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_samples.size() == 0) begin
            report_mismatch("unexpected word", rsp_bus.result_word, 64'd0);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_bus.result_word !== want.word)
               report_mismatch("result_word", rsp_bus.result_word, want.word);
            if (rsp_bus.format_unsupported !== want.unsup)
               report_mismatch("format_unsupported", 64'(rsp_bus.format_unsupported),
                               64'(want.unsup));
            if (rsp_bus.block_last_out !== want.last)
               report_mismatch("block_last_out", 64'(rsp_bus.block_last_out),
                               64'(want.last));
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= idle_pct);
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // offer one word from a falling edge until accepted
   task automatic send_word(input logic op, input logic [63:0] dev, input logic [31:0] flt,
                            input logic last, input sample_out_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.operation = op;
      req_bus.device_word = dev;
      req_bus.float_word = flt;
      req_bus.block_last = last;
      do @(posedge clock); while (!req_bus.ready);
      pending_samples = {pending_samples, want};
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // wait for every result, settle, then write the format
   task automatic write_format(input logic [2:0] fmt);
      while (pending_samples.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = fmt;
      @(negedge clock);
      csr_write_enable = 1'b0;
      active_fmt = fmt;
   endtask

   function automatic logic [63:0] random_device_word();
      case ($urandom_range(5))
         0: return {$urandom, $urandom};
         1: return {{48{$urandom_range(1) == 1}}, 16'($urandom)};
         2: return {$urandom, 8'($urandom_range(1) ? 8'hFF : 8'h00), 24'($urandom)};
         3: return {1'($urandom), 11'(1023 - $urandom_range(40)), 20'($urandom), $urandom};
         4: begin
            case ($urandom_range(3))
               0: return {1'($urandom), 11'h7FF, 20'($urandom_range(1) ? $urandom : 0),
                          $urandom_range(1) ? $urandom : 32'd0};
               1: return {1'($urandom), 11'd0, 20'($urandom), $urandom};
               2: return {1'($urandom), 11'(872 + $urandom_range(30)), 20'($urandom), $urandom};
               default: return {1'($urandom), 11'(1150 + $urandom_range(8)), 20'($urandom),
                                $urandom};
            endcase
         end
         // exact halfway points for single rounding
         default: return {1'($urandom), 11'(870 + $urandom_range(290)), 20'($urandom),
                          3'($urandom), 29'h1000_0000};
      endcase
   endfunction

   function automatic logic [31:0] random_float_word();
      case ($urandom_range(3))
         0: return $urandom;
         1: return {1'($urandom), 8'(127 - $urandom_range(30)), 23'($urandom)};
         2: begin
            case ($urandom_range(3))
               0: return {1'($urandom), 8'hFF, $urandom_range(1) ? 23'($urandom) : 23'd0};
               1: return {1'($urandom), 8'h00, $urandom_range(1) ? 23'($urandom) : 23'd0};
               2: return {1'($urandom), 8'd127, $urandom_range(1) ? 23'($urandom) : 23'd0};
               default: return {1'($urandom), 8'd126, 23'h7FFFFF - 23'($urandom_range(3))};
            endcase
         end
         default: return {1'($urandom), 8'(110 + $urandom_range(17)), 23'($urandom)};
      endcase
   endfunction

   // directed table: typed expectations only where obvious
   initial begin
      stim_table = '{
         // reset format is float32
         '{FMT_F32, OP_DECODE, 64'h0000_0000_3F80_0000, 32'h0, 1'b1, 1'b1,
           64'h3F80_0000, 1'b0},
         '{FMT_F32, OP_DECODE, 64'hFFFF_FFFF_7FC1_2345, 32'hFFFF_FFFF, 1'b0, 1'b1,
           64'h7FC1_2345, 1'b0},
         '{FMT_F32, OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FC0_0001, 1'b0, 1'b1,
           64'h3F80_0000, 1'b0},
         '{FMT_F32, OP_ENCODE, 64'h0, 32'hFF80_0000, 1'b1, 1'b1, 64'hBF80_0000, 1'b0},
         '{FMT_F32, OP_ENCODE, 64'h0, 32'h8000_0000, 1'b0, 1'b1, 64'h8000_0000, 1'b0},
         '{FMT_F32, OP_ENCODE, 64'h0, 32'h4000_0000, 1'b0, 1'b1, 64'h3F80_0000, 1'b0},
         '{FMT_INT16, OP_DECODE, 64'h0000_0000_0000_8000, 32'h0, 1'b0, 1'b1,
           64'hBF80_0000, 1'b0},
         '{FMT_INT16, OP_DECODE, 64'hFFFF_FFFF_FFFF_0000, 32'h0, 1'b1, 1'b1, 64'h0, 1'b0},
         '{FMT_INT16, OP_DECODE, 64'h0000_0000_0000_7FFF, 32'h0, 1'b0, 1'b0, 64'h0, 1'b0},
         '{FMT_INT16, OP_ENCODE, 64'h0, 32'h3F80_0000, 1'b0, 1'b1, 64'h7FFF, 1'b0},
         '{FMT_INT16, OP_ENCODE, 64'h0, 32'hBF80_0000, 1'b0, 1'b1, 64'h8001, 1'b0},
         '{FMT_INT16, OP_ENCODE, 64'h0, 32'h7FFF_FFFF, 1'b0, 1'b1, 64'h7FFF, 1'b0},
         '{FMT_INT24, OP_DECODE, 64'hFFFF_FFFF_FF80_0000, 32'h0, 1'b0, 1'b1,
           64'hBF80_0000, 1'b0},
         '{FMT_INT24, OP_DECODE, 64'h0000_0000_007F_FFFF, 32'h0, 1'b1, 1'b0, 64'h0, 1'b0},
         '{FMT_INT24, OP_ENCODE, 64'h0, 32'h3F80_0000, 1'b0, 1'b1, 64'h7F_FFFF, 1'b0},
         '{FMT_INT24, OP_ENCODE, 64'h0, 32'hBF80_0000, 1'b0, 1'b1, 64'h80_0001, 1'b0},
         '{FMT_INT32, OP_DECODE, 64'h0000_0000_8000_0000, 32'h0, 1'b0, 1'b1,
           64'hBF80_0000, 1'b0},
         '{FMT_INT32, OP_DECODE, 64'h0000_0000_7FFF_FFFF, 32'h0, 1'b0, 1'b0, 64'h0, 1'b0},
         '{FMT_INT32, OP_ENCODE, 64'h0, 32'h3F80_0000, 1'b1, 1'b1, 64'h7FFF_FFFF, 1'b0},
         '{FMT_INT32, OP_ENCODE, 64'h0, 32'hBF80_0000, 1'b0, 1'b1, 64'h8000_0000, 1'b0},
         '{FMT_F64, OP_DECODE, 64'h3FF0_0000_0000_0000, 32'h0, 1'b0, 1'b1,
           64'h3F80_0000, 1'b0},
         '{FMT_F64, OP_DECODE, 64'hFFF0_0000_0000_0000, 32'h0, 1'b0, 1'b1,
           64'hFF80_0000, 1'b0},
         '{FMT_F64, OP_DECODE, 64'hFFF8_0000_2000_0001, 32'h0, 1'b0, 1'b0, 64'h0, 1'b0},
         '{FMT_F64, OP_ENCODE, 64'h0, 32'h7F80_0000, 1'b1, 1'b1,
           64'h3FF0_0000_0000_0000, 1'b0},
         '{FMT_UNSUP, OP_DECODE, 64'h3FF0_0000_0000_0000, 32'h3F80_0000, 1'b1, 1'b1,
           64'h0, 1'b1},
         '{FMT_SPARE7, OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h3F80_0000, 1'b0, 1'b1,
           64'h0, 1'b1}
      };
   end

   // main sequence
   initial begin
      logic [2:0] phase_fmt[14];
      sample_out_type want;
      logic op;
      logic [63:0] dev;
      logic [31:0] flt;
      logic last;
      phase_fmt = '{FMT_INT16, FMT_INT24, FMT_INT32, FMT_F32, FMT_F64, FMT_UNSUP,
                    FMT_SPARE6, FMT_SPARE7, FMT_INT32, FMT_INT16, FMT_F64, FMT_INT24,
                    FMT_F32, FMT_INT16};
      hold_request = 0;
      idle_pct = 36;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 3'd0;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_DECODE;
      req_bus.device_word = 64'd0;
      req_bus.float_word = 32'd0;
      req_bus.block_last = 1'b0;
      active_fmt = FMT_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows, format rewritten where the row asks
      #0;
      foreach (stim_table[i]) begin
         if (stim_table[i].fmt != active_fmt) write_format(stim_table[i].fmt);
         want = convert_sample(active_fmt, stim_table[i].op, stim_table[i].dev,
                               stim_table[i].flt, stim_table[i].last);
         if (stim_table[i].typed) begin
            want.word = stim_table[i].want_word;
            want.unsup = stim_table[i].want_unsup;
         end
         send_word(stim_table[i].op, stim_table[i].dev, stim_table[i].flt,
                   stim_table[i].last, want);
      end

      // random phases over the formats
      foreach (phase_fmt[p]) begin
         write_format(phase_fmt[p]);
         idle_pct = (p == 3 || p == 10) ? 0 : 36;
         if (p == 5 || p == 12) hold_request++;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            op = 1'($urandom);
            dev = random_device_word();
            flt = random_float_word();
            last = ($urandom_range(7) == 0);
            want = convert_sample(active_fmt, op, dev, flt, last);
            send_word(op, dev, flt, last, want);
         end
      end

      // drain and settle
      while (pending_samples.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
